// File: src/delimiter_split_with_escape_prefix_top_assert.svh
// Assertion macros used by the tokenizer top module.
`ifndef DELIMITER_SPLIT_WITH_ESCAPE_PREFIX_TOP_ASSERT_SVH
`define DELIMITER_SPLIT_WITH_ESCAPE_PREFIX_TOP_ASSERT_SVH

// Same-cycle implication on clk, off during reset.
`define DSEP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on clk, off during reset.
`define DSEP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/dsep_pkg.sv
package dsep_pkg;

	localparam int DEF_MAX_SEPARATOR = 8;
	localparam int DEF_MAX_ESCAPE    = 8;
	localparam int DEF_POSITION_BITS = 16;

	localparam int BYTE_W      = 8;
	localparam int CFG_W       = 64;
	localparam int LEN_W       = 4;
	localparam int TOKEN_POS_W = 16;
	localparam int IDX_W       = 5;

	typedef enum logic [1:0] {
		REG_SEP_BYTES = 2'd0,
		REG_SEP_LEN   = 2'd1,
		REG_ESC_BYTES = 2'd2,
		REG_ESC_LEN   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic sep_match;
		logic escaped;
	} match_t;

endpackage

// File: src/delimiter_split_with_escape_prefix_top.sv
// A byte passes through the input register, and its token word, if any, through the result registers.
// Throughput: one byte per cycle unless output stalls; separator and escape compares run in parallel on the window.
// Reset (arst_n low, asynchronous): separator length 1; other configuration, stream state and valid flags zero.
// End of text clears the stream state after that byte; configuration registers keep their values.
`include "delimiter_split_with_escape_prefix_top_assert.svh"

module delimiter_split_with_escape_prefix_top import dsep_pkg::*; #(
	parameter int MAX_SEPARATOR = DEF_MAX_SEPARATOR,
	parameter int MAX_ESCAPE    = DEF_MAX_ESCAPE,
	parameter int POSITION_BITS = DEF_POSITION_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  cfg_reg_t                   cfg_addr,
	input  logic [CFG_W-1:0]           cfg_wdata,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [BYTE_W-1:0]          s_tdata,  // data_byte
	input  logic                       s_tlast,  // end_of_text
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [2*TOKEN_POS_W-1:0]   m_tdata,  // token_start, token_end
	output logic                       m_tlast,  // is_final_token
	output logic                       m_tuser   // length_overflow
);

	localparam int WIN   = MAX_SEPARATOR + MAX_ESCAPE;
	localparam int HIST  = (WIN > 1) ? WIN - 1 : 1;
	localparam int P     = POSITION_BITS;
	localparam int EXT_W = (P > TOKEN_POS_W) ? P : TOKEN_POS_W;
	localparam logic [P-1:0] MAXPOS = '1;

	logic [CFG_W-1:0] sep_bytes_q;
	logic [LEN_W-1:0] sep_len_q;
	logic [CFG_W-1:0] esc_bytes_q;
	logic [LEN_W-1:0] esc_len_q;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	logic              adv_s1;

	logic [HIST-1:0][BYTE_W-1:0] hist_q;
	logic [P-1:0] pos_q;
	logic [P-1:0] tok_q;
	logic         split_q;
	logic         ovf_q;

	logic                 m_valid_q;
	logic [TOKEN_POS_W-1:0] start_q;
	logic [TOKEN_POS_W-1:0] end_q;
	logic                 final_q;
	logic                 ovf_out_q;

	logic [WIN-1:0][BYTE_W-1:0] win;
	logic [LEN_W-1:0] sl_eff;
	logic [LEN_W-1:0] el_eff;
	match_t           mres;
	logic [P:0]       seen;
	logic [P:0]       sep_start_w;
	logic [P-1:0]     sep_start;
	logic [P-1:0]     next_pos;
	logic             at_max;
	logic             ovf_now;
	logic             hit;
	logic             emit;
	logic [P-1:0]     end_pos;
	logic [EXT_W-1:0] ext_start;
	logic [EXT_W-1:0] ext_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_bytes_q <= '0;
			sep_len_q   <= LEN_W'(1);
			esc_bytes_q <= '0;
			esc_len_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_SEP_BYTES: sep_bytes_q <= cfg_wdata;
				REG_SEP_LEN:   sep_len_q   <= cfg_wdata[LEN_W-1:0];
				REG_ESC_BYTES: esc_bytes_q <= cfg_wdata;
				REG_ESC_LEN:   esc_len_q   <= cfg_wdata[LEN_W-1:0];
				default:       sep_len_q   <= sep_len_q;
			endcase
		end
	end

	assign adv_s1   = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_comb begin
		win[0] = byte_s1;
		for (int i = 1; i < WIN; i++) win[i] = hist_q[i-1];
	end

	always_comb begin
		if (sep_len_q == '0)
			sl_eff = LEN_W'(1);
		else if (sep_len_q > LEN_W'(MAX_SEPARATOR))
			sl_eff = LEN_W'(MAX_SEPARATOR);
		else
			sl_eff = sep_len_q;
		if (esc_len_q > LEN_W'(MAX_ESCAPE))
			el_eff = LEN_W'(MAX_ESCAPE);
		else
			el_eff = esc_len_q;
	end

	dsep_match #(
		.MAX_SEPARATOR(MAX_SEPARATOR),
		.MAX_ESCAPE   (MAX_ESCAPE),
		.WIN          (WIN)
	) u_match (
		.win      (win),
		.sep_bytes(sep_bytes_q),
		.sep_len  (sl_eff),
		.esc_bytes(esc_bytes_q),
		.esc_len  (el_eff),
		.result   (mres)
	);

	always_comb begin
		at_max      = (pos_q == MAXPOS);
		ovf_now     = ovf_q || at_max;
		next_pos    = at_max ? MAXPOS : pos_q + P'(1);
		seen        = {1'b0, pos_q} + (P+1)'(1);
		sep_start_w = seen - (P+1)'(sl_eff);
		sep_start   = sep_start_w[P-1:0];
		hit = (seen >= (P+1)'(sl_eff)) && (sep_start_w >= (P+1)'(el_eff))
			&& (sep_start >= tok_q) && mres.sep_match && !mres.escaped;
		emit      = hit || (last_s1 && split_q);
		end_pos   = hit ? sep_start : next_pos;
		ext_start = EXT_W'(tok_q);
		ext_end   = EXT_W'(end_pos);
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			hist_q[0] <= byte_s1;
			for (int i = 1; i < HIST; i++) hist_q[i] <= hist_q[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			tok_q   <= '0;
			split_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				pos_q   <= '0;
				tok_q   <= '0;
				split_q <= 1'b0;
				ovf_q   <= 1'b0;
			end else begin
				pos_q   <= next_pos;
				tok_q   <= hit ? next_pos : tok_q;
				split_q <= split_q || hit;
				ovf_q   <= ovf_now;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv_s1) begin
			m_valid_q <= emit;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			start_q   <= ext_start[TOKEN_POS_W-1:0];
			end_q     <= ext_end[TOKEN_POS_W-1:0];
			final_q   <= !hit;
			ovf_out_q <= ovf_now;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {end_q, start_q};
	assign m_tlast  = final_q;
	assign m_tuser  = ovf_out_q;

	`DSEP_ASSERT_NEXT(a_clear_at_end, adv_s1 && last_s1,
		pos_q == '0 && tok_q == '0 && !split_q && !ovf_q, "stream state not cleared")
	`DSEP_ASSERT_NOW(a_ovf_saturated, ovf_q, pos_q == MAXPOS, "overflow without saturation")
	`DSEP_ASSERT_NOW(a_tok_behind_pos, 1'b1, tok_q <= pos_q, "token start ahead of position")

endmodule

// File: src/dsep_match.sv
module dsep_match import dsep_pkg::*; #(
	parameter int MAX_SEPARATOR = DEF_MAX_SEPARATOR,
	parameter int MAX_ESCAPE    = DEF_MAX_ESCAPE,
	parameter int WIN           = DEF_MAX_SEPARATOR + DEF_MAX_ESCAPE
) (
	input  logic [WIN-1:0][BYTE_W-1:0] win,
	input  logic [CFG_W-1:0]           sep_bytes,
	input  logic [LEN_W-1:0]           sep_len,
	input  logic [CFG_W-1:0]           esc_bytes,
	input  logic [LEN_W-1:0]           esc_len,
	output match_t                     result
);

	function automatic logic [BYTE_W-1:0] pick(input logic [WIN-1:0][BYTE_W-1:0] w,
			input logic [IDX_W-1:0] idx);
		logic [BYTE_W-1:0] b;
		b = '0;
		for (int i = 0; i < WIN; i++) begin
			if (IDX_W'(i) == idx) b = w[i];
		end
		return b;
	endfunction

	always_comb begin
		logic             sep_ok;
		logic             esc_ok;
		logic [IDX_W-1:0] idx;
		sep_ok = 1'b1;
		esc_ok = 1'b1;
		idx    = '0;
		for (int k = 0; k < MAX_SEPARATOR; k++) begin
			if (LEN_W'(k) < sep_len) begin
				idx = IDX_W'(sep_len) - IDX_W'(1) - IDX_W'(k);
				if (pick(win, idx) != sep_bytes[BYTE_W*k +: BYTE_W]) sep_ok = 1'b0;
			end
		end
		for (int k = 0; k < MAX_ESCAPE; k++) begin
			if (LEN_W'(k) < esc_len) begin
				idx = IDX_W'(sep_len) + IDX_W'(esc_len) - IDX_W'(1) - IDX_W'(k);
				if (pick(win, idx) != esc_bytes[BYTE_W*k +: BYTE_W]) esc_ok = 1'b0;
			end
		end
		result.sep_match = sep_ok;
		result.escaped   = esc_ok && (esc_len != '0);
	end

endmodule

// File: dv/token_span_checker.sv
`timescale 1ns / 1ps

module token_span_checker import dsep_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  cfg_reg_t                 cfg_addr,
	input  logic [CFG_W-1:0]         cfg_wdata,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	input  logic [BYTE_W-1:0]        s_tdata,
	input  logic                     s_tlast,
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic [2*TOKEN_POS_W-1:0] m_tdata,
	input  logic                     m_tlast,
	input  logic                     m_tuser,
	output int                       span_errors,
	output int                       spans_pending
);

	localparam int POS_MAX = (1 << DEF_POSITION_BITS) - 1;

	typedef struct packed {
		logic [TOKEN_POS_W-1:0] start_pos;
		logic [TOKEN_POS_W-1:0] end_pos;
		logic                   last_tok;
		logic                   ovf;
	} span_t;

	logic [CFG_W-1:0] sep_word;
	logic [LEN_W-1:0] sep_len;
	logic [CFG_W-1:0] esc_word;
	logic [LEN_W-1:0] esc_len;

	logic [BYTE_W-1:0] hist [16];
	int bpos;
	int tok_start;
	int blocked;
	bit split_seen;
	bit ovf_seen;

	span_t span_q [$];
	int err_cnt;

	function automatic void clear_text();
		foreach (hist[i]) hist[i] = '0;
		bpos = 0;
		tok_start = 0;
		blocked = 0;
		split_seen = 1'b0;
		ovf_seen = 1'b0;
	endfunction

	function automatic bit tokenize_byte(input logic [7:0] din, input logic eot,
			output span_t sp);
		int sl, el, seen, nxt, sep_at, k;
		bit hit, escaped, emit;
		sl = (sep_len == 0) ? 1 : (sep_len > DEF_MAX_SEPARATOR) ? DEF_MAX_SEPARATOR : sep_len;
		el = (esc_len > DEF_MAX_ESCAPE) ? DEF_MAX_ESCAPE : esc_len;
		hit = 1'b0;
		emit = 1'b0;
		sep_at = 0;
		sp = '0;
		for (k = 15; k > 0; k--) hist[k] = hist[k-1];
		hist[0] = din;
		seen = bpos + 1;
		if (bpos >= POS_MAX) begin
			ovf_seen = 1'b1;
			nxt = POS_MAX;
		end else begin
			nxt = bpos + 1;
		end
		if (seen >= sl) begin
			sep_at = seen - sl;
			hit = (sep_at >= el) && (sep_at >= blocked);
			for (k = 0; k < sl; k++)
				if (hist[(sl - 1 - k) & 15] != sep_word[8*k +: 8]) hit = 1'b0;
			if (hit && el > 0) begin
				escaped = 1'b1;
				for (k = 0; k < el; k++)
					if (hist[(sl + el - 1 - k) & 15] != esc_word[8*k +: 8]) escaped = 1'b0;
				if (escaped) hit = 1'b0;
			end
		end
		if (hit) begin
			if (sep_at > POS_MAX) sep_at = POS_MAX;
			sp.start_pos = tok_start[15:0];
			sp.end_pos = sep_at[15:0];
			sp.last_tok = 1'b0;
			sp.ovf = ovf_seen;
			emit = 1'b1;
			tok_start = nxt;
			blocked = nxt;
			split_seen = 1'b1;
		end else if (eot && split_seen) begin
			sp.start_pos = tok_start[15:0];
			sp.end_pos = nxt[15:0];
			sp.last_tok = 1'b1;
			sp.ovf = ovf_seen;
			emit = 1'b1;
		end
		bpos = nxt;
		if (eot) clear_text();
		return emit;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		span_t want, got;
		if (!arst_n) begin
			sep_word = '0;
			sep_len = 4'd1;
			esc_word = '0;
			esc_len = '0;
			clear_text();
			span_q.delete();
			err_cnt = 0;
			span_errors <= 0;
			spans_pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.start_pos = m_tdata[TOKEN_POS_W-1:0];
				got.end_pos = m_tdata[2*TOKEN_POS_W-1:TOKEN_POS_W];
				got.last_tok = m_tlast;
				got.ovf = m_tuser;
				if (span_q.size() == 0) begin
					err_cnt++;
					$display("%0t unexpected token word: start=%0d end=%0d final=%0b ovf=%0b",
						$time, got.start_pos, got.end_pos, got.last_tok, got.ovf);
				end else begin
					want = span_q.pop_front();
					if (got.start_pos != want.start_pos || got.end_pos != want.end_pos ||
							got.last_tok != want.last_tok || got.ovf != want.ovf) begin
						err_cnt++;
						$display("%0t token word: expected start=%0d end=%0d final=%0b ovf=%0b, got start=%0d end=%0d final=%0b ovf=%0b",
							$time, want.start_pos, want.end_pos, want.last_tok, want.ovf,
							got.start_pos, got.end_pos, got.last_tok, got.ovf);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (tokenize_byte(s_tdata, s_tlast, want)) span_q.push_back(want);
			end
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_SEP_BYTES: sep_word = cfg_wdata;
					REG_SEP_LEN:   sep_len = cfg_wdata[LEN_W-1:0];
					REG_ESC_BYTES: esc_word = cfg_wdata;
					REG_ESC_LEN:   esc_len = cfg_wdata[LEN_W-1:0];
					default: ;
				endcase
			end
			span_errors <= err_cnt;
			spans_pending <= span_q.size();
		end
	end

endmodule

// File: dv/tb_delimiter_split_with_escape_prefix_top.sv
`timescale 1ns / 1ps

module tb_delimiter_split_with_escape_prefix_top;
	import dsep_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int RX_HOLD = 400;

	typedef logic [7:0] byte_q_t [$];

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	cfg_reg_t cfg_addr = REG_SEP_BYTES;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [BYTE_W-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [2*TOKEN_POS_W-1:0] m_tdata;
	logic m_tlast;
	logic m_tuser;

	int span_errors;
	int spans_pending;
	int snd_idle = 30;
	int rcv_idle = 59;
	bit rx_stall_req = 1'b0;
	int quiet = 0;

	logic [63:0] sep_w, esc_w;
	int sl_eff, el_eff;

	delimiter_split_with_escape_prefix_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	token_span_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.m_tuser       (m_tuser),
		.span_errors   (span_errors),
		.spans_pending (spans_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (rx_stall_req) begin
				rx_stall_req = 1'b0;
				m_tready <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("delimiter_split_with_escape_prefix_top: mismatch");
				$finish;
			end
		end
	end

	task automatic put_byte(input logic [7:0] b, input logic eot);
		if ($urandom_range(99) < snd_idle) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= eot;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (spans_pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_text(input byte_q_t txt, input bit pause_mid);
		for (int i = 0; i < txt.size(); i++) begin
			// hold the sender until every token word so far has drained
			if (pause_mid && i > 0 && i == txt.size() / 2) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (spans_pending != 0);
			end
			put_byte(txt[i], i == txt.size() - 1);
		end
	endtask

	task automatic load_config(input logic [63:0] sb, input logic [3:0] sl,
			input logic [63:0] eb, input logic [3:0] el);
		settle();
		sep_w = sb;
		esc_w = eb;
		sl_eff = (sl == 0) ? 1 : (sl > DEF_MAX_SEPARATOR) ? DEF_MAX_SEPARATOR : sl;
		el_eff = (el > DEF_MAX_ESCAPE) ? DEF_MAX_ESCAPE : el;
		cfg_wr_en <= 1'b1;
		cfg_addr <= REG_SEP_BYTES;
		cfg_wdata <= sb;
		@(posedge clk);
		cfg_addr <= REG_SEP_LEN;
		cfg_wdata <= 64'(sl);
		@(posedge clk);
		cfg_addr <= REG_ESC_BYTES;
		cfg_wdata <= eb;
		@(posedge clk);
		cfg_addr <= REG_ESC_LEN;
		cfg_wdata <= 64'(el);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_phase(input int items);
		int sent, len, r, j, cut;
		logic [63:0] sb, eb;
		logic [3:0] sl, el;
		byte_q_t txt;
		sent = 0;
		while (sent < items) begin
			sb = {$urandom, $urandom};
			eb = {$urandom, $urandom};
			case ($urandom_range(9))
				0: sb = '0;
				1: sb = '1;
				2: eb = '1;
				3: eb = sb;
				default: ;
			endcase
			sl = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 3));
			el = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(0, 2));
			load_config(sb, sl, eb, el);
			repeat ($urandom_range(1, 5)) begin
				txt.delete();
				len = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
				while (txt.size() < len) begin
					r = $urandom_range(99);
					if (r < 42) begin
						if (r >= 25)
							for (j = 0; j < el_eff; j++) txt.push_back(esc_w[8*j +: 8]);
						if (r < 35)
							for (j = 0; j < sl_eff; j++) txt.push_back(sep_w[8*j +: 8]);
					end else if (r < 50) begin
						cut = $urandom_range(sl_eff - 1);
						for (j = 0; j < cut; j++) txt.push_back(sep_w[8*j +: 8]);
					end else if (r < 62) begin
						txt.push_back(8'($urandom_range(255)));
					end else begin
						j = $urandom_range(15);
						if (j < 8 || el_eff == 0)
							txt.push_back(sep_w[8*(j % sl_eff) +: 8]);
						else
							txt.push_back(esc_w[8*(j % el_eff) +: 8]);
					end
				end
				sent += txt.size();
				send_text(txt, $urandom_range(29) == 0);
			end
		end
	endtask

	initial begin
		byte_q_t burst;
		int i;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// separator ends on the last byte; then a text with no split
		load_config(64'h0, 4'd1, 64'h0, 4'd0);
		send_text('{8'hFF, 8'h00, 8'hFF, 8'h00}, 1'b0);
		send_text('{8'hFF}, 1'b0);
		// zero separator length, one-byte escape: escaped separator, prefix too early
		load_config(64'h2C, 4'd0, 64'h5C, 4'd1);
		send_text('{8'h61, 8'h2C, 8'h5C, 8'h2C, 8'h62}, 1'b0);
		send_text('{8'h2C, 8'h78}, 1'b0);
		// both lengths above range; text shorter than the separator
		load_config('1, 4'd15, 64'h0, 4'd15);
		send_text('{8'hFF, 8'hFF, 8'hFF}, 1'b0);
		// overlapping separator candidates
		load_config(64'h6161, 4'd2, 64'h0, 4'd0);
		send_text('{8'h61, 8'h61, 8'h61, 8'h61}, 1'b0);

		// long receiver hold-off while the sender keeps offering
		load_config(64'h2C, 4'd1, 64'h0, 4'd0);
		for (i = 0; i < 200; i++)
			burst.push_back(($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'h2C);
		rx_stall_req = 1'b1;
		send_text(burst, 1'b1);

		random_phase(350);
		snd_idle = 59;
		rcv_idle = 30;
		random_phase(350);
		snd_idle = 0;
		rcv_idle = 0;
		random_phase(350);

		settle();
		if (span_errors == 0 && spans_pending == 0)
			$display("delimiter_split_with_escape_prefix_top: match");
		else
			$display("delimiter_split_with_escape_prefix_top: mismatch");
		$finish;
	end

endmodule
